// ----- hdl/izh_pkg.sv -----
`timescale 1ns / 1ps
// Package for the Izhikevich neuron update block.
// Holds fixed-point formats, constants and saturation helpers; no dependencies.
package izh_pkg;

   localparam int Q8_W = 22;
   localparam int NEURONS_DEF = 1024;
   localparam int HISTORY_WORDS_DEF = 2;
   localparam int IDX_W = 10;
   localparam int THR_W = 16;
   localparam int PA_W = 16;
   localparam int PB_W = 16;
   localparam logic [THR_W-1:0] THR_RESET = 16'd7680;
   localparam logic signed [Q8_W-1:0] V_RESET = -22'sd16640;
   localparam logic signed [Q8_W-1:0] U_RESET = -22'sd3328;
   localparam logic signed [15:0] COEF_004 = 16'sd2621;
   localparam logic signed [23:0] C140 = 24'sd35840;
   localparam int HALF_STEPS = 2;

   typedef logic signed [Q8_W-1:0] q8_type;

   function automatic q8_type sat22(input logic signed [47:0] x);
      if (x > 48'sd2097151) begin
         return 22'sd2097151;
      end else if (x < -48'sd2097152) begin
         return -22'sd2097152;
      end
      return x[Q8_W-1:0];
   endfunction

endpackage

// ----- hdl/izh_stage.sv -----
`timescale 1ns / 1ps
// One Euler half step of the Izhikevich equations, three register stages.
// Depends on izh_pkg.
module izh_stage
   import izh_pkg::*;
#(
   parameter int TAG_W = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic [TAG_W-1:0]        in_tag,
   input  q8_type                  in_v,
   input  q8_type                  in_u,
   input  q8_type                  in_i,
   input  logic [PA_W-1:0]         in_a,
   input  logic signed [PB_W-1:0]  in_b,
   input  logic [THR_W-1:0]        in_thr,
   output logic                    out_valid,
   output logic [TAG_W-1:0]        out_tag,
   output q8_type                  out_v,
   output q8_type                  out_u
);

   // stage 1: v*v, then 0.04 scale
   logic [2:0] vld_ff;
   logic [TAG_W-1:0] tag1_ff, tag2_ff, tag3_ff;
   q8_type v1_ff, u1_ff, i1_ff, v2_ff, u2_ff, u3_ff, v3_ff;
   logic [PA_W-1:0] a1_ff, a2_ff, a3_ff;
   logic signed [PB_W-1:0] b1_ff, b2_ff;
   logic run1_ff, run2_ff, run3_ff;
   logic signed [43:0] vv1_ff;
   logic signed [37:0] bv3_ff;

   logic run0;
   logic signed [60:0] sq_full;
   logic signed [47:0] sq, dv, vsum;
   q8_type vnew;
   logic signed [47:0] diff, prod, usum;

   assign run0 = ($signed({1'b0, in_thr}) > $signed({in_v[Q8_W-1], in_v}));

   always_comb begin
      sq_full = vv1_ff * $signed({1'b0, COEF_004}) + 61'sd8388608;
      sq = 48'(sq_full >>> 24);
      dv = sq + 48'(v1_ff) * 48'sd5 + 48'(C140) - 48'(u1_ff) + 48'(i1_ff);
      vsum = 48'(v1_ff) + (dv >>> 1);
      vnew = sat22(vsum);
      diff = 48'(bv3_ff >>> 14) - 48'(u3_ff);
      prod = 48'(diff * $signed({1'b0, a3_ff}));
      usum = 48'(u3_ff) + (prod >>> 17);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[1:0], in_valid};
      end
      tag1_ff <= in_tag; v1_ff <= in_v; u1_ff <= in_u; i1_ff <= in_i;
      a1_ff <= in_a; b1_ff <= in_b; run1_ff <= run0;
      vv1_ff <= in_v * in_v;
      tag2_ff <= tag1_ff; u2_ff <= u1_ff; a2_ff <= a1_ff; b2_ff <= b1_ff;
      run2_ff <= run1_ff;
      v2_ff <= run1_ff ? vnew : v1_ff;
      tag3_ff <= tag2_ff; u3_ff <= u2_ff; a3_ff <= a2_ff; v3_ff <= v2_ff;
      run3_ff <= run2_ff;
      bv3_ff <= b2_ff * v2_ff;
   end

   assign out_valid = vld_ff[2];
   assign out_tag = tag3_ff;
   assign out_v = v3_ff;
   assign out_u = run3_ff ? sat22(usum) : u3_ff;

endmodule

// ----- hdl/izhikevich_neuron_update.sv -----
`timescale 1ns / 1ps
// Izhikevich neuron update: top level with state memories and result skid.
// Depends on izh_pkg and izh_stage.
// Takes one request per clock for distinct neurons while the result queue has
// room. Each request reads the neuron's voltage, recovery and spike history
// from on-chip memories, runs two half-step Euler stages and writes the state
// back; the result is registered and pushed into the result queue. A request
// for a neuron that is still in flight is held until that neuron's write-back
// has landed. After reset a clearing pass writes the reset state into every
// memory entry; requests wait during it.
module izhikevich_neuron_update
   import izh_pkg::*;
#(
   parameter int NEURONS = NEURONS_DEF,
   parameter int HISTORY_WORDS = HISTORY_WORDS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [THR_W-1:0]         csr_spike_threshold,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [IDX_W-1:0]         req_neuron,
   input  q8_type                   req_input_current,
   input  logic [PA_W-1:0]          req_param_a,
   input  logic signed [PB_W-1:0]   req_param_b,
   input  q8_type                   req_param_c,
   input  q8_type                   req_param_d,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [IDX_W-1:0]         rsp_neuron_out,
   output logic                     rsp_spiked,
   output q8_type                   rsp_new_voltage,
   output q8_type                   rsp_new_recovery
);

   localparam int AW = (NEURONS > 1) ? $clog2(NEURONS) : 1;
   localparam int HB = 32 * HISTORY_WORDS;
   localparam int LAT = 9;
   localparam int FIFO_D = 16;
   localparam int FP_W = 5;
   localparam int TAG_W = 1;

   typedef enum logic [1:0] {
      ST_CLEAR = 2'b01,
      ST_RUN   = 2'b10
   } state_type;

   typedef struct packed {
      logic [IDX_W-1:0] n;
      logic             inr;
      logic [AW-1:0]    addr;
      q8_type           i;
      logic [PA_W-1:0]  a;
      logic signed [PB_W-1:0] b;
      q8_type           c;
      q8_type           d;
   } item_type;

   typedef struct packed {
      logic [IDX_W-1:0] n;
      logic             spk;
      q8_type           v;
      q8_type           u;
   } res_type;

   state_type st_ff, st_in;
   logic [AW:0] clr_ff;
   logic [THR_W-1:0] thr_ff;

   q8_type mem_v [NEURONS];
   q8_type mem_u [NEURONS];
   logic [HB-1:0] mem_h [NEURONS];
   q8_type rd_v_ff, rd_u_ff;
   logic [HB-1:0] rd_h_ff;

   // shift line of request items through the pipe
   item_type it_ff [LAT];
   logic [LAT-1:0] vl_ff;

   logic acc;
   logic [FP_W:0] cnt_ff;
   item_type in_it;

   assign csr_ready = 1'b1;
   assign acc = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_valid) begin
         thr_ff <= csr_spike_threshold;
      end
   end

   always_comb begin
      in_it.n = req_neuron;
      in_it.inr = (32'(req_neuron) < NEURONS);
      in_it.addr = AW'(req_neuron);
      in_it.i = req_input_current;
      in_it.a = req_param_a;
      in_it.b = req_param_b;
      in_it.c = req_param_c;
      in_it.d = req_param_d;
   end

   // accepted request -> memory read; stage 0 has read data
   logic wr_en;
   logic [AW-1:0] wr_addr;
   q8_type wr_v, wr_u;
   logic [HB-1:0] wr_h;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_v[wr_addr] <= wr_v;
         mem_u[wr_addr] <= wr_u;
         mem_h[wr_addr] <= wr_h;
      end
      rd_v_ff <= mem_v[in_it.addr];
      rd_u_ff <= mem_u[in_it.addr];
      rd_h_ff <= mem_h[in_it.addr];
   end

   // forward the write-back bus into the read stage
   q8_type s_v, s_u;
   logic [HB-1:0] s_h;

   always_comb begin
      s_v = rd_v_ff;
      s_u = rd_u_ff;
      s_h = rd_h_ff;
      if (wr_en && wr_addr == it_ff[0].addr) begin
         s_v = wr_v;
         s_u = wr_u;
         s_h = wr_h;
      end
   end

   // Hazard: an item in the arithmetic pipe for the same neuron has not
   // written yet. Interlock: hold the request while the same neuron is in flight.
   logic hazard;
   always_comb begin
      hazard = 1'b0;
      for (int k = 0; k < LAT; k++) begin
         if (vl_ff[k] && it_ff[k].inr && it_ff[k].addr == in_it.addr) begin
            hazard = 1'b1;
         end
      end
   end

   assign req_ready = (st_ff == ST_RUN) && !hazard && (cnt_ff < FP_W'(FIFO_D - 1));

   logic [HB-1:0] h_pipe_ff [LAT];

   // Euler stages
   logic s1_vld, s2_vld;
   q8_type s1_v, s1_u, s2_v, s2_u;
   logic [TAG_W-1:0] s1_t, s2_t;

   izh_stage #(.TAG_W(TAG_W)) u_st1 (
      .clock(clock), .reset(reset), .in_valid(vl_ff[0]), .in_tag(1'b0),
      .in_v(s_v), .in_u(s_u), .in_i(it_ff[0].i), .in_a(it_ff[0].a),
      .in_b(it_ff[0].b), .in_thr(thr_ff),
      .out_valid(s1_vld), .out_tag(s1_t), .out_v(s1_v), .out_u(s1_u));

   izh_stage #(.TAG_W(TAG_W)) u_st2 (
      .clock(clock), .reset(reset), .in_valid(s1_vld), .in_tag(s1_t),
      .in_v(s1_v), .in_u(s1_u), .in_i(it_ff[3].i), .in_a(it_ff[3].a),
      .in_b(it_ff[3].b), .in_thr(thr_ff),
      .out_valid(s2_vld), .out_tag(s2_t), .out_v(s2_v), .out_u(s2_u));

   // final stage at it_ff[6]: spike decision, register into it_ff[7] slot
   logic spk;
   q8_type fv, fu;
   logic [HB-1:0] fh;
   assign spk = $signed({s2_v[Q8_W-1], s2_v}) >= $signed({1'b0, thr_ff});
   always_comb begin
      fh = {spk, h_pipe_ff[6][HB-1:1]};
      fv = spk ? it_ff[6].c : s2_v;
      fu = spk ? sat22(48'(s2_u) + 48'(it_ff[6].d)) : s2_u;
   end

   res_type res_ff;
   logic res_inr_ff;
   logic [AW-1:0] res_a_ff;
   logic [HB-1:0] res_h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vl_ff <= '0;
      end else begin
         vl_ff <= {vl_ff[LAT-2:0], acc};
      end
      it_ff[0] <= in_it;
      for (int k = 1; k < LAT; k++) begin
         it_ff[k] <= it_ff[k-1];
      end
      h_pipe_ff[1] <= s_h;
      for (int k = 2; k < LAT; k++) begin
         h_pipe_ff[k] <= h_pipe_ff[k-1];
      end
      h_pipe_ff[0] <= '0;
      res_ff.n <= it_ff[6].n;
      res_ff.spk <= it_ff[6].inr ? spk : 1'b0;
      res_ff.v <= it_ff[6].inr ? fv : '0;
      res_ff.u <= it_ff[6].inr ? fu : '0;
      res_inr_ff <= it_ff[6].inr;
      res_a_ff <= it_ff[6].addr;
      res_h_ff <= fh;
   end

   // write back at stage 7 (vl_ff[7])
   always_comb begin
      if (st_ff == ST_CLEAR) begin
         wr_en = 1'b1;
         wr_addr = clr_ff[AW-1:0];
         wr_v = V_RESET;
         wr_u = U_RESET;
         wr_h = '0;
      end else begin
         wr_en = vl_ff[7] && res_inr_ff;
         wr_addr = res_a_ff;
         wr_v = res_ff.v;
         wr_u = res_ff.u;
         wr_h = res_h_ff;
      end
   end

   // clearing pass
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_CLEAR: if (32'(clr_ff) == NEURONS - 1) st_in = ST_RUN;
         ST_RUN: st_in = ST_RUN;
         default: st_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_CLEAR;
         clr_ff <= '0;
      end else begin
         st_ff <= st_in;
         if (st_ff == ST_CLEAR) clr_ff <= clr_ff + 1'b1;
      end
   end

   // result queue
   res_type q_ff [FIFO_D];
   logic [3:0] wp_ff, rp_ff;
   logic push, pop;
   assign push = vl_ff[7];
   assign pop = rsp_valid && rsp_ready;
   assign rsp_valid = wp_ff != rp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 1'b1;
         if (pop) rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (acc ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
      end
      if (push) q_ff[wp_ff] <= res_ff;
   end

   assign rsp_neuron_out = q_ff[rp_ff].n;
   assign rsp_spiked = q_ff[rp_ff].spk;
   assign rsp_new_voltage = q_ff[rp_ff].v;
   assign rsp_new_recovery = q_ff[rp_ff].u;

   assert property (@(posedge clock) disable iff (reset) cnt_ff <= FP_W'(FIFO_D))
      else $error("result queue overflow");
   assert property (@(posedge clock) disable iff (reset) st_ff == ST_CLEAR |-> !req_ready)
      else $error("request taken during clear");
   assert property (@(posedge clock) disable iff (reset)
      acc |=> ##7 vl_ff[7])
      else $error("pipeline lost a request");

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// Testbench for izhikevich_neuron_update: drives neuron update requests and
// threshold writes, predicts each result in-bench and checks it field by field.
// Depends on izh_pkg and the izhikevich_neuron_update RTL.
module tb;
   import izh_pkg::*;

   typedef struct {
      logic [IDX_W-1:0]       neuron;
      q8_type                 current;
      logic [PA_W-1:0]        a;
      logic signed [PB_W-1:0] b;
      q8_type                 c;
      q8_type                 d;
   } neuron_req_type;

   typedef struct {
      logic [IDX_W-1:0] neuron;
      logic             spiked;
      q8_type           voltage;
      q8_type           recovery;
   } neuron_rsp_type;

   logic clock = 0;
   logic reset = 1;
   logic csr_valid = 0;
   logic csr_ready;
   logic [THR_W-1:0] csr_spike_threshold = '0;
   logic req_valid = 0;
   logic req_ready;
   logic [IDX_W-1:0] req_neuron = '0;
   q8_type req_input_current = '0;
   logic [PA_W-1:0] req_param_a = '0;
   logic signed [PB_W-1:0] req_param_b = '0;
   q8_type req_param_c = '0;
   q8_type req_param_d = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic [IDX_W-1:0] rsp_neuron_out;
   logic rsp_spiked;
   q8_type rsp_new_voltage;
   q8_type rsp_new_recovery;

   longint model_v[NEURONS_DEF];
   longint model_u[NEURONS_DEF];
   logic [63:0] model_hist[NEURONS_DEF];
   longint model_thr;
   neuron_rsp_type pending_updates[$];
   int errors = 0;
   bit calm = 0;

   izhikevich_neuron_update u_dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #3ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   always @(posedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= 32);
   end

   function automatic longint clamp22(input longint x);
      if (x > 2097151) return 2097151;
      if (x < -2097152) return -2097152;
      return x;
   endfunction

   function automatic neuron_rsp_type update_neuron(input neuron_req_type r);
      neuron_rsp_type res;
      longint v, u, sq, dv, bv;
      bit fire;
      v = model_v[r.neuron];
      u = model_u[r.neuron];
      for (int i = 0; i < HALF_STEPS && v < model_thr; i++) begin
         sq = (v * v * 2621 + (longint'(1) << 23)) >>> 24;
         dv = sq + 5 * v + 35840 - u + longint'(r.current);
         v = clamp22(v + (dv >>> 1));
         bv = (longint'(r.b) * v) >>> 14;
         u = clamp22(u + ((longint'(r.a) * (bv - u)) >>> 17));
      end
      fire = v >= model_thr;
      model_hist[r.neuron] = {fire, model_hist[r.neuron][63:1]};
      if (fire) begin
         v = longint'(r.c);
         u = clamp22(u + longint'(r.d));
      end
      model_v[r.neuron] = v;
      model_u[r.neuron] = u;
      res.neuron = r.neuron;
      res.spiked = fire;
      res.voltage = v[Q8_W-1:0];
      res.recovery = u[Q8_W-1:0];
      return res;
   endfunction

   always @(posedge clock) begin
      neuron_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_updates.size() == 0) begin
            $display("%0t: unexpected response neuron %0d", $time, rsp_neuron_out);
            errors++;
         end else begin
            want = pending_updates.pop_front();
            if (rsp_neuron_out !== want.neuron) begin
               $display("%0t: neuron exp %0d got %0d", $time, want.neuron, rsp_neuron_out);
               errors++;
            end
            if (rsp_spiked !== want.spiked) begin
               $display("%0t: spiked exp %0d got %0d", $time, want.spiked, rsp_spiked);
               errors++;
            end
            if (rsp_new_voltage !== want.voltage) begin
               $display("%0t: voltage exp %0d got %0d", $time, want.voltage,
                        rsp_new_voltage);
               errors++;
            end
            if (rsp_new_recovery !== want.recovery) begin
               $display("%0t: recovery exp %0d got %0d", $time, want.recovery,
                        rsp_new_recovery);
               errors++;
            end
         end
      end
   end

   task automatic send_update(input neuron_req_type r);
      if (!calm && $urandom_range(99) < 32) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1;
      req_neuron <= r.neuron;
      req_input_current <= r.current;
      req_param_a <= r.a;
      req_param_b <= r.b;
      req_param_c <= r.c;
      req_param_d <= r.d;
      do @(posedge clock); while (!req_ready);
      pending_updates.push_back(update_neuron(r));
   endtask

   task automatic drain;
      req_valid <= 0;
      @(posedge clock);
      while (pending_updates.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [THR_W-1:0] thr);
      drain();
      csr_valid <= 1;
      csr_spike_threshold <= thr;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      model_thr = longint'(thr);
   endtask

   function automatic neuron_req_type tonic_req(input int span);
      neuron_req_type r;
      r.neuron = IDX_W'($urandom_range(span - 1));
      r.current = Q8_W'($urandom_range(0, 20 * 256));
      r.a = PA_W'($urandom_range(600, 6600));
      r.b = PB_W'($urandom_range(2500, 4200));
      r.c = -22'sd16640 + Q8_W'($urandom_range(0, 3840));
      r.d = Q8_W'($urandom_range(0, 8 * 256));
      return r;
   endfunction

   function automatic neuron_req_type noise_req();
      neuron_req_type r;
      r.neuron = IDX_W'($urandom);
      r.current = Q8_W'($urandom);
      r.a = PA_W'($urandom);
      r.b = PB_W'($urandom);
      r.c = Q8_W'($urandom);
      r.d = Q8_W'($urandom);
      return r;
   endfunction

   task automatic test_directed;
      neuron_req_type r;
      r = '{neuron: 0, current: 0, a: 0, b: 0, c: 0, d: 0};
      send_update(r);
      r = '{neuron: 1023, current: 22'sd2097151, a: 16'hFFFF, b: 16'sh7FFF,
            c: 22'sd2097151, d: 22'sd2097151};
      send_update(r);
      send_update(r);
      r = '{neuron: 2, current: -22'sd2097152, a: 16'hFFFF, b: -16'sd32768,
            c: -22'sd2097152, d: -22'sd2097152};
      send_update(r);
      send_update(r);
      send_update(r);
      // force a spike with a reset voltage above threshold, then spike with no step
      r = '{neuron: 5, current: 22'sd200000, a: 1311, b: 3277, c: 22'sd20000,
            d: 22'sd2048};
      send_update(r);
      send_update(r);
      send_update(r);
      for (int i = 0; i < 12; i++) begin
         r = tonic_req(4);
         r.current = 22'sd2560;
         send_update(r);
      end
      drain();
   endtask

   task automatic test_threshold_extremes;
      write_threshold(16'd0);
      for (int i = 0; i < 40; i++) send_update(tonic_req(8));
      write_threshold(16'hFFFF);
      for (int i = 0; i < 40; i++) send_update(tonic_req(8));
      write_threshold(THR_RESET);
   endtask

   task automatic test_random_tonic;
      for (int phase = 0; phase < 4; phase++) begin
         write_threshold(phase == 3 ? THR_RESET : 16'($urandom_range(0, 16'hFFFF)));
         for (int i = 0; i < 300; i++) send_update(tonic_req(phase[0] ? 3 : 64));
      end
   endtask

   task automatic test_noise;
      write_threshold(16'($urandom));
      for (int i = 0; i < 200; i++) begin
         send_update($urandom_range(1) ? noise_req() : tonic_req(1024));
      end
   endtask

   task automatic test_back_to_back;
      calm = 1;
      write_threshold(THR_RESET);
      for (int i = 0; i < 250; i++) send_update(tonic_req(2));
      drain();
      calm = 0;
   endtask

   initial begin
      model_thr = longint'(THR_RESET);
      for (int i = 0; i < NEURONS_DEF; i++) begin
         model_v[i] = -16640;
         model_u[i] = -3328;
         model_hist[i] = '0;
      end
      repeat (5) @(posedge clock);
      reset <= 0;
      test_directed();
      test_threshold_extremes();
      test_random_tonic();
      test_noise();
      test_back_to_back();
      drain();
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hdl/izh_pkg.sv
hdl/izh_stage.sv
hdl/izhikevich_neuron_update.sv
tb/sv/tb.sv
